// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lfbp_pkg.sv -----
// Types and constants of the LSB-first bit packer.
package lfbp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned HELD_W  = 7;
    localparam int unsigned HCNT_W  = 3;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_ZERO = 4'd0;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd8;
    localparam logic [BYTE_W-1:0]  PAD_ONES   = 8'hFF;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [HELD_W-1:0]  held_t;
    typedef logic [HCNT_W-1:0]  hcnt_t;

    typedef struct packed {
        logic   mode;
        byte_t  data_byte;
        count_t bit_count;
    } item_t;

endpackage

// ----- rtl/lfbp_in_if.sv -----
// Input channel of the bit packer: one append or flush item per beat.
interface lfbp_in_if;
    logic                valid;
    logic                ready;
    logic                mode;
    lfbp_pkg::byte_t     data_byte;
    lfbp_pkg::count_t    bit_count;

    modport source (output valid, output mode, output data_byte, output bit_count,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input bit_count,
                    output ready);
endinterface

// ----- rtl/lfbp_out_if.sv -----
// Result channel of the bit packer: one packed byte or error per beat.
interface lfbp_out_if;
    logic                valid;
    logic                ready;
    lfbp_pkg::byte_t     out_byte;
    logic                error;

    modport source (output valid, output out_byte, output error, input ready);
    modport sink   (input valid, input out_byte, input error, output ready);
endinterface

// ----- rtl/lsb_first_bit_packer_unit.sv -----
// LSB-first bit packer: packs 1 to 8 bit groups into bytes, flushes with ones padding.
//
// Takes one item per clock when the result side keeps up. An accepted beat lands in
// an input register; from there a single pass of shift, mask and count logic
// against the held bits updates the holder and, if a byte completes, a flush finds
// bits held, or an append carries zero bits, loads the result register. Items that
// give no result pass the compute stage even while the result register is stalled;
// an item that gives a result waits in the input register until the result register
// is free.
`include "assert_macros.svh"

module lsb_first_bit_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    lfbp_in_if.sink     item,
    lfbp_out_if.source  result
);
    import lfbp_pkg::*;

    logic  s1_valid_reg;
    item_t s1_item_reg;
    held_t held_bits_reg,  held_bits_next;
    hcnt_t held_count_reg, held_count_next;
    logic  out_valid_reg;
    byte_t out_byte_reg,   out_byte_next;
    logic  out_error_reg,  out_error_next;

    logic            has_result;
    logic            out_free;
    logic            s1_fire;
    count_t          cnt_sat;
    byte_t           masked;
    logic [14:0]     combined;
    logic [COUNT_W-1:0] total;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && (out_free || !has_result);
    assign item.ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        cnt_sat  = (s1_item_reg.bit_count > COUNT_MAX) ? COUNT_MAX : s1_item_reg.bit_count;
        masked   = s1_item_reg.data_byte & ~(PAD_ONES << cnt_sat);
        combined = {8'd0, held_bits_reg} | ({7'd0, masked} << held_count_reg);
        total    = {1'b0, held_count_reg} + cnt_sat;

        has_result      = 1'b0;
        held_bits_next  = held_bits_reg;
        held_count_next = held_count_reg;
        out_byte_next   = '0;
        out_error_next  = 1'b0;

        if (s1_item_reg.mode == MODE_FLUSH)
        begin
            if (held_count_reg != '0)
            begin
                has_result      = 1'b1;
                out_byte_next   = {1'b0, held_bits_reg} | (PAD_ONES << held_count_reg);
                held_bits_next  = '0;
                held_count_next = '0;
            end
        end
        else if (s1_item_reg.bit_count == COUNT_ZERO)
        begin
            has_result     = 1'b1;
            out_error_next = 1'b1;
        end
        else if (total >= COUNT_MAX)
        begin
            has_result      = 1'b1;
            out_byte_next   = combined[7:0];
            held_bits_next  = combined[14:8];
            held_count_next = total[HCNT_W-1:0];
        end
        else
        begin
            held_bits_next  = combined[HELD_W-1:0];
            held_count_next = total[HCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            held_bits_reg  <= '0;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s1_fire)
            begin
                held_bits_reg  <= held_bits_next;
                held_count_reg <= held_count_next;
            end
            if (s1_fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_item_reg.mode      <= item.mode;
            s1_item_reg.data_byte <= item.data_byte;
            s1_item_reg.bit_count <= item.bit_count;
        end
        if (s1_fire && has_result)
        begin
            out_byte_reg  <= out_byte_next;
            out_error_reg <= out_error_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.error    = out_error_reg;

    `ASSERT_IMPLY(a_error_byte_zero, out_valid_reg && out_error_reg, out_byte_reg == '0)
    `ASSERT_NEXT(a_flush_empties, s1_fire && s1_item_reg.mode == MODE_FLUSH,
        held_count_reg == '0 && held_bits_reg == '0)
    `ASSERT_NEXT(a_no_overwrite, out_valid_reg && !result.ready,
        out_valid_reg && $stable(out_byte_reg) && $stable(out_error_reg))
    `ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_fire,
        s1_valid_reg && $stable(s1_item_reg))

endmodule
